// ===== hdl/sitoa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, control/status types and the digit encoder for the signed itoa block.
package sitoa_pkg;

	localparam int VALUE_BITS = 32;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 6;
	localparam int REM_W      = 6;
	localparam int ADDR_W     = $clog2(VALUE_BITS);
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int BIT_W      = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [REM_W-1:0]  DIGIT_DEC_MAX = REM_W'(9);
	localparam logic [CHAR_W-1:0] DEC_BASE   = CHAR_W'(10);

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
		logic emit_sign;
		logic emit_digit;
		logic emit_term;
	} sitoa_cmd_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic div_last;
		logic quo_zero;
		logic cnt_last;
		logic neg;
		logic idx_one;
		logic out_free;
	} sitoa_sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
		logic [CHAR_W-1:0] wide;
		wide = CHAR_W'(d);
		if (d > DIGIT_DEC_MAX)
			return wide - DEC_BASE + CHAR_ALPHA;
		else
			return wide + CHAR_ZERO;
	endfunction

endpackage

// ===== hdl/sitoa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: steps the divider per digit, then emits sign, buffered digits, zero byte.
module sitoa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sitoa_pkg::sitoa_sts_t sts,
	output sitoa_pkg::sitoa_cmd_t cmd
);
	import sitoa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMMIT,
		ST_SIGN,
		ST_FETCH,
		ST_DIGIT,
		ST_TERM
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last)
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					// Stop on a zero quotient or a full buffer.
					if (sts.quo_zero || sts.cnt_last)
						state_q <= sts.neg ? ST_SIGN : ST_FETCH;
					else
						state_q <= ST_DIV;
				end
				ST_SIGN: begin
					if (sts.out_free)
						state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					if (sts.out_free)
						state_q <= sts.idx_one ? ST_TERM : ST_FETCH;
				end
				ST_TERM: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign cmd.load       = (state_q == ST_IDLE) && in_valid;
	assign cmd.step       = (state_q == ST_DIV);
	assign cmd.commit     = (state_q == ST_COMMIT);
	assign cmd.emit_sign  = (state_q == ST_SIGN) && sts.out_free;
	assign cmd.emit_digit = (state_q == ST_DIGIT) && sts.out_free;
	assign cmd.emit_term  = (state_q == ST_TERM) && sts.out_free;

endmodule

// ===== hdl/sitoa_dp.sv =====
`timescale 1ns / 1ps
// Datapath: magnitude and radix registers, bit-serial divider, digit buffer, output register.
module sitoa_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [sitoa_pkg::VALUE_BITS-1:0] value,
	input  logic        [sitoa_pkg::RADIX_W-1:0]  radix,
	input  sitoa_pkg::sitoa_cmd_t                 cmd,
	output sitoa_pkg::sitoa_sts_t                 sts,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [sitoa_pkg::CHAR_W-1:0]   character,
	output logic                                  last,
	output logic        [sitoa_pkg::LEN_W-1:0]    total_length
);
	import sitoa_pkg::*;

	logic [VALUE_BITS-1:0] quo_q;
	logic [REM_W-1:0]      rem_q;
	logic [RADIX_W-1:0]    rad_q;
	logic                  neg_q;
	logic [BIT_W-1:0]      bit_cnt_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEN_W-1:0]      len_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q;
	logic [LEN_W-1:0]      out_len_q;

	logic [REM_W-1:0]      digit_mem [VALUE_BITS];
	logic [REM_W-1:0]      rd_data_q;
	logic [ADDR_W-1:0]     rd_addr;

	logic [VALUE_BITS-1:0] value_u;
	logic [VALUE_BITS-1:0] mag;
	logic [RADIX_W-1:0]    rad_clamp;
	logic [REM_W:0]        trial;
	logic [REM_W:0]        diff;
	logic                  ge;
	logic                  emit_any;

	always_comb begin
		value_u = VALUE_BITS'(value);
		mag     = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
		if (radix < RADIX_MIN)
			rad_clamp = RADIX_MIN;
		else if (radix > RADIX_MAX)
			rad_clamp = RADIX_MAX;
		else
			rad_clamp = radix;
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		ge    = trial >= {1'b0, rad_q};
		diff  = trial - {1'b0, rad_q};
	end

	assign emit_any = cmd.emit_sign | cmd.emit_digit | cmd.emit_term;
	assign rd_addr  = ADDR_W'(cnt_q - CNT_W'(1));

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q <= '0;
				cnt_q     <= '0;
				len_q     <= '0;
			end else if (cmd.step) begin
				bit_cnt_q <= bit_cnt_q + BIT_W'(1);
			end else if (cmd.commit) begin
				bit_cnt_q <= '0;
				cnt_q     <= cnt_q + CNT_W'(1);
			end else if (cmd.emit_digit) begin
				cnt_q     <= cnt_q - CNT_W'(1);
			end
			if (emit_any)
				len_q <= len_q + LEN_W'(1);
			out_valid_q <= emit_any | (out_valid_q & ~out_ready);
		end
	end

	// Divider and payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= mag;
			rem_q <= '0;
			rad_q <= rad_clamp;
			neg_q <= value_u[VALUE_BITS-1];
		end else if (cmd.step) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end else if (cmd.commit) begin
			rem_q <= '0;
		end
		if (cmd.emit_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
			out_len_q  <= '0;
		end else if (cmd.emit_digit) begin
			out_char_q <= digit_char(rd_data_q);
			out_last_q <= 1'b0;
			out_len_q  <= '0;
		end else if (cmd.emit_term) begin
			out_char_q <= CHAR_NUL;
			out_last_q <= 1'b1;
			out_len_q  <= len_q + LEN_W'(1);
		end
	end

	// Digit buffer: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.commit)
			digit_mem[cnt_q[ADDR_W-1:0]] <= rem_q;
		rd_data_q <= digit_mem[rd_addr];
	end

	assign sts.div_last = (bit_cnt_q == BIT_W'(VALUE_BITS - 1));
	assign sts.quo_zero = (quo_q == '0);
	assign sts.cnt_last = (cnt_q == CNT_W'(VALUE_BITS - 1));
	assign sts.neg      = neg_q;
	assign sts.idx_one  = (cnt_q == CNT_W'(1));
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid    = out_valid_q;
	assign character    = out_char_q;
	assign last         = out_last_q;
	assign total_length = out_len_q;

endmodule

// ===== hdl/signed_int_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Top level of the signed integer to ASCII text converter.
//
// Input channel (in_valid/in_ready): one beat carries a signed value and a radix. Radix
// values below 2 act as 2, above 36 act as 36.
// Output channel (out_valid/out_ready): one beat per character, most significant first:
// an optional '-', the digits ('0'-'9', 'A'-'Z'), then a zero byte with last high and
// total_length holding the character count including that zero byte.
// Digits come from a restoring divider that retires one quotient bit per cycle, so each
// digit takes VALUE_BITS shift/subtract steps followed by a buffer write.
// Emission then loads the optional sign, each digit (buffer read, then output load) and
// the zero byte into the output register, waiting out any out_ready stall.
// in_ready is high only while the sequencer is idle, which it returns to as soon as the
// zero byte is loaded, so the next value is taken while that final beat still waits.
// A stalled receiver holds the output register; the sequencer waits with it.
// Reset clears the sequencer, the output valid and the counters; the digit buffer is not
// cleared since each item writes every entry it later reads.
module signed_int_to_ascii_radix (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [sitoa_pkg::VALUE_BITS-1:0] value,
	input  logic        [sitoa_pkg::RADIX_W-1:0]    radix,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic        [sitoa_pkg::CHAR_W-1:0]     character,
	output logic                                    last,
	output logic        [sitoa_pkg::LEN_W-1:0]      total_length
);
	import sitoa_pkg::*;

	sitoa_cmd_t cmd;
	sitoa_sts_t sts;

	// Sequencer: owns the input handshake and paces divider and emission.
	sitoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: divider, digit buffer and the output register.
	sitoa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.radix        (radix),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last         (last),
		.total_length (total_length)
	);

endmodule
